### design/jas_pkg.sv
package jas_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 14;
    localparam int NUM_AXES        = 4;
    localparam int DB_NARROW       = 150;
    localparam int DB_YAW          = 300;
    localparam int SPAN_MARGIN     = 10;
    localparam int CFG_IDX_BITS    = 2;

    // Register indexes of the calibration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRUST = 2'd0,
        CFG_ROLL   = 2'd1,
        CFG_PITCH  = 2'd2,
        CFG_YAW    = 2'd3
    } cfg_idx_t;

    // Reset calibration: centre 2^(sb-1), both spans 2^(sb-1)-1 (2048 and 2047 at 12 bits).
    function automatic logic [63:0] cal_reset(input int sb);
        logic [63:0] r;
        begin
            r = (64'd1 << (sb - 1))
              | (((64'd1 << (sb - 1)) - 64'd1) << sb)
              | (((64'd1 << (sb - 1)) - 64'd1) << (2 * sb));
            return r;
        end
    endfunction

endpackage

### design/joystick_axis_scaler_unit.sv
// Channel  | Handshake              | Payload
// s_axis   | s_axis_tvalid/tready   | tdata: thrust, roll, pitch, yaw raw
// m_axis   | m_axis_tvalid/tready   | tdata: four fractions; tuser: span_fault
// cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data (calibration)
//
// One item per cycle is accepted while m_axis is not stalled. The pipeline has:
// one registered front stage, SAMPLE_BITS+FRAC_BITS+3 restoring-division cells
// (one per quotient bit), one output register. The whole pipeline advances
// only when the output register is free or taken, so a stall on m_axis backs
// up to s_axis. Reset restores all four calibrations to centre 2048, spans
// 2047 (scaled to the sample width).
module joystick_axis_scaler_unit
    import jas_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // thrust_raw, roll_raw, pitch_raw, yaw_raw from the lowest bit up
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // thrust_frac, roll_frac, pitch_frac, yaw_frac from the lowest bit up
    output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // span_fault: bit 0 thrust, 1 roll, 2 pitch, 3 yaw
    output logic [3:0]                 m_axis_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [3*SAMPLE_BITS-1:0]   cfg_data
);

    localparam int OW = FRAC_BITS + 2;
    localparam int OBW = ((4*OW+7)/8)*8;
    localparam logic [3*SAMPLE_BITS-1:0] CAL_RST = (3*SAMPLE_BITS)'(cal_reset(SAMPLE_BITS));

    logic [3*SAMPLE_BITS-1:0] cal_reg [NUM_AXES];
    logic adv;
    logic [NUM_AXES-1:0] lv;
    logic [OW-1:0] lf [NUM_AXES];
    logic [NUM_AXES-1:0] lflt;
    logic          out_valid_reg;
    logic [OBW-1:0] out_data_reg;
    logic [3:0]    out_user_reg;

    assign cfg_ready = 1'b1;

    // Calibration registers; indexes above the list do not exist at this width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                cal_reg[i] <= CAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRUST: cal_reg[0] <= cfg_data;
                CFG_ROLL:   cal_reg[1] <= cfg_data;
                CFG_PITCH:  cal_reg[2] <= cfg_data;
                CFG_YAW:    cal_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // The chain moves whenever the output register can take a new item.
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        jas_axis_lane #(
            .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS),
            .DB(a == 3 ? DB_YAW : DB_NARROW)
        ) u_lane (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(s_axis_tvalid),
            .raw(s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
            .cal(cal_reg[a]),
            .out_valid(lv[a]), .frac(lf[a]), .fault(lflt[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= lv[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= OBW'({lf[3], lf[2], lf[1], lf[0]});
            out_user_reg <= lflt;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

### design/jas_div_cell.sv
// One restoring-division step. Each cell produces one quotient bit and
// hands the partial remainder, divisor and side data to the next cell.
module jas_div_cell
    import jas_pkg::*;
#(
    parameter int RW = 32,
    parameter int QW = 16,
    parameter int SW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [RW-1:0] in_num,
    input  logic [RW-1:0] in_div,
    input  logic [QW-1:0] in_quo,
    input  logic [SW-1:0] in_side,
    input  logic          adv,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [RW-1:0] out_num,
    output logic [RW-1:0] out_div,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg, num_reg, div_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] side_reg;
    logic [RW:0]   trial;
    logic [RW-1:0] rem_next;
    logic          bit_next;

    always_comb
    begin
        trial = {in_rem, in_num[RW-1]};
        if (trial >= {1'b0, in_div})
        begin
            rem_next = RW'(trial - {1'b0, in_div});
            bit_next = 1'b1;
        end
        else
        begin
            rem_next = trial[RW-1:0];
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {in_num[RW-2:0], 1'b0};
            div_reg  <= in_div;
            quo_reg  <= {in_quo[QW-2:0], bit_next};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

### design/jas_axis_lane.sv
// One axis: centre, deadband, divisor select and rounding offset in a registered
// front stage, a chain of division cells, then saturation, sign and fault zeroing.
module jas_axis_lane
    import jas_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int DB          = DB_NARROW
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] raw,
    input  logic [3*SAMPLE_BITS-1:0] cal,
    output logic                   out_valid,
    output logic [FRAC_BITS+1:0]   frac,
    output logic                   fault
);

    localparam int VW = SAMPLE_BITS + 2;
    // Numerator is 2*|v|*2^F + d; the signed quotient needs F+2 bits after saturation
    // but the raw quotient can be larger, so keep all bits.
    localparam int RW = SAMPLE_BITS + FRAC_BITS + 3;
    localparam int QW = RW;
    localparam int NC = RW;
    localparam int SW = 2;

    logic signed [VW-1:0] v, vdb, d;
    logic [VW-1:0] mag;
    logic [RW-1:0] num0, div0;
    logic          flt, neg;

    logic          f_valid_reg;
    logic [RW-1:0] f_num_reg, f_div_reg;
    logic          f_flt_reg, f_neg_reg;

    always_comb
    begin
        v = $signed({2'b00, raw}) - $signed({2'b00, cal[SAMPLE_BITS-1:0]});
        if (v > -$signed(VW'(DB)) && v < $signed(VW'(DB)))
            vdb = '0;
        else if (v > 0)
            vdb = v - $signed(VW'(DB));
        else
            vdb = v + $signed(VW'(DB));
        neg = vdb[VW-1];
        d = (neg ? $signed({2'b00, cal[3*SAMPLE_BITS-1:2*SAMPLE_BITS]})
                 : $signed({2'b00, cal[2*SAMPLE_BITS-1:SAMPLE_BITS]}))
            - $signed(VW'(DB + SPAN_MARGIN));
        flt  = (d <= 0);
        mag  = neg ? VW'(-vdb) : VW'(vdb);
        num0 = (RW'(mag) << (FRAC_BITS + 1)) + RW'(unsigned'(d));
        div0 = flt ? RW'(1) : (RW'(unsigned'(d)) << 1);
    end

    // The front stage is registered so the first division cell starts clean.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_reg <= num0;
            f_div_reg <= div0;
            f_flt_reg <= flt;
            f_neg_reg <= neg;
        end
    end

    logic          c_valid [NC+1];
    logic [RW-1:0] c_rem [NC+1], c_num [NC+1], c_div [NC+1];
    logic [QW-1:0] c_quo [NC+1];
    logic [SW-1:0] c_side [NC+1];

    assign c_valid[0] = f_valid_reg;
    assign c_rem[0]   = '0;
    assign c_num[0]   = f_num_reg;
    assign c_div[0]   = f_div_reg;
    assign c_quo[0]   = '0;
    assign c_side[0]  = {f_flt_reg, f_neg_reg};

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        jas_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(c_valid[i]), .in_rem(c_rem[i]), .in_num(c_num[i]),
            .in_div(c_div[i]), .in_quo(c_quo[i]), .in_side(c_side[i]),
            .adv(adv),
            .out_valid(c_valid[i+1]), .out_rem(c_rem[i+1]), .out_num(c_num[i+1]),
            .out_div(c_div[i+1]), .out_quo(c_quo[i+1]), .out_side(c_side[i+1])
        );
    end

    logic [QW-1:0] q;
    logic [FRAC_BITS+1:0] qs;

    always_comb
    begin
        q = c_quo[NC];
        if (q > QW'(1 << FRAC_BITS))
            q = QW'(1 << FRAC_BITS);
        qs = c_side[NC][0] ? (FRAC_BITS+2)'(-q) : q[FRAC_BITS+1:0];
        if (c_side[NC][1])
            qs = '0;
    end

    assign out_valid = c_valid[NC];
    assign frac      = qs;
    assign fault     = c_side[NC][1];

endmodule

### design/jas_checker.sv
module jas_checker
    import jas_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_fault0: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("faulted thrust not zero");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384
                        && $signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("thrust out of range");

endmodule

bind joystick_axis_scaler_unit jas_checker u_jas_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
